// ===== hw/rtl/dwta_pkg.sv =====
package dwta_pkg;

  localparam int CostW    = 32;
  localparam int CfgW     = 9;
  localparam int DispW    = 16;
  localparam int BestW    = 8;
  localparam int DenW     = CostW + 2;
  localparam int NumW     = CostW + 4;
  localparam int DivSteps = NumW;
  localparam int DivCntW  = $clog2(DivSteps);
  localparam int SumW     = NumW + 2;
  localparam int QMax     = 32767;
  localparam int QMin     = -32768;

  localparam logic [CfgW-1:0] CountReset  = 9'd64;
  localparam logic [CfgW-1:0] OffsetReset = 9'd0;

  localparam logic CfgDispCount  = 1'b0;
  localparam logic CfgDispOffset = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_DIV  = 5'b00100,
    S_FIX  = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  typedef struct packed {
    logic accept;
    logic start;
    logic prep;
    logic div_step;
    logic fix;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic refine;
    logic div_done;
  } status_t;

endpackage

// ===== hw/rtl/dwta_cost_if.sv =====
interface dwta_cost_if import dwta_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CostW-1:0] cost;

  modport source (output valid, output cost, input ready);
  modport sink (input valid, input cost, output ready);
endinterface

// ===== hw/rtl/dwta_disp_if.sv =====
interface dwta_disp_if import dwta_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [DispW-1:0] disparity_q4;
  logic [BestW-1:0]        best_index;
  logic                    refined;

  modport source (output valid, output disparity_q4, output best_index, output refined,
                  input ready);
  modport sink (input valid, input disparity_q4, input best_index, input refined,
                output ready);
endinterface

// ===== hw/rtl/dwta_ctrl.sv =====
module dwta_ctrl import dwta_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output logic    busy_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign busy_o     = (state_q != S_IDLE);
  assign in_ready_o = !(st_i.last && busy_o);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.accept = accept;
    cmd_o.start  = accept && st_i.last;
    out_valid_d  = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.start) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = st_i.refine;
        if (!st_i.refine || st_i.div_done) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/dwta_dp.sv =====
module dwta_dp import dwta_pkg::*; #(
  parameter int MAX_DISPARITIES = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [CfgW-1:0]         cfg_wdata_i,
  input  logic [CostW-1:0]        cost_i,
  input  cmd_t                    cmd_i,
  output status_t                 st_o,
  output logic signed [DispW-1:0] disparity_q4_o,
  output logic [BestW-1:0]        best_index_o,
  output logic                    refined_o
);

  localparam int IdxW     = $clog2(MAX_DISPARITIES);
  localparam int CmpW     = (IdxW + 1 > CfgW) ? IdxW + 1 : CfgW;
  localparam int BaseW    = (IdxW + 2 > CfgW + 1) ? IdxW + 2 : CfgW + 1;
  localparam int AW       = BaseW + 4;
  localparam int BestExtW = (IdxW > BestW) ? IdxW : BestW;

  // configuration
  logic [CfgW-1:0]        count_q;
  logic signed [CfgW-1:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= CountReset;
      offset_q <= $signed(OffsetReset);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgDispCount:  count_q  <= cfg_wdata_i;
        CfgDispOffset: offset_q <= $signed(cfg_wdata_i);
      endcase
    end
  end

  // per-pixel search state
  logic [IdxW-1:0]  idx_q, low_idx_q;
  logic [CostW-1:0] prev_q, low_q, left_q, right_q;
  logic             await_q;

  logic [CmpW-1:0]  n_eff, idx_next;
  logic             last, take, interior;
  logic [IdxW-1:0]  nlow_idx;
  logic [CostW-1:0] nlow, nleft, nright;
  logic             nawait;

  always_comb begin
    n_eff = (count_q == '0) ? CmpW'(1) : CmpW'(count_q);
    if (n_eff > CmpW'(MAX_DISPARITIES)) begin
      n_eff = CmpW'(MAX_DISPARITIES);
    end
    idx_next = CmpW'(idx_q) + CmpW'(1);
    last     = (idx_next >= n_eff);

    take     = (idx_q == '0) || (cost_i < low_q);
    nlow     = low_q;
    nlow_idx = low_idx_q;
    nleft    = left_q;
    nright   = right_q;
    nawait   = await_q;
    if (take) begin
      nlow     = cost_i;
      nlow_idx = idx_q;
      nleft    = prev_q;
      nawait   = 1'b1;
    end else if (await_q) begin
      nright = cost_i;
      nawait = 1'b0;
    end
    interior = (nlow_idx != '0) && ((CmpW'(nlow_idx) + CmpW'(1)) < n_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      prev_q    <= '0;
      low_q     <= '0;
      low_idx_q <= '0;
      left_q    <= '0;
      right_q   <= '0;
      await_q   <= 1'b0;
    end else if (cmd_i.accept) begin
      if (last) begin
        idx_q     <= '0;
        prev_q    <= '0;
        low_q     <= '0;
        low_idx_q <= '0;
        left_q    <= '0;
        right_q   <= '0;
        await_q   <= 1'b0;
      end else begin
        idx_q     <= idx_next[IdxW-1:0];
        prev_q    <= cost_i;
        low_q     <= nlow;
        low_idx_q <= nlow_idx;
        left_q    <= nleft;
        right_q   <= nright;
        await_q   <= nawait;
      end
    end
  end

  // snapshot of the finished pixel
  logic [CostW-1:0] s_c0_q, s_c1_q, s_c2_q;
  logic [IdxW-1:0]  s_best_q;
  logic             s_int_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      s_c0_q   <= nleft;
      s_c1_q   <= nlow;
      s_c2_q   <= nright;
      s_best_q <= nlow_idx;
      s_int_q  <= interior;
    end
  end

  // parabola terms
  logic signed [CostW+2:0] dsum;
  logic signed [CostW:0]   diff;
  logic [CostW-1:0]        absdiff;
  logic signed [BaseW-1:0] base;

  always_comb begin
    dsum = $signed({3'b000, s_c0_q}) + $signed({3'b000, s_c2_q})
         - $signed({2'b00, s_c1_q, 1'b0});
    diff = $signed({1'b0, s_c0_q}) - $signed({1'b0, s_c2_q});
    absdiff = diff[CostW] ? CostW'(-diff) : diff[CostW-1:0];
    base = BaseW'(offset_q) + $signed(BaseW'(s_best_q));
  end

  logic [DenW-1:0]      den_q;
  logic [DenW-1:0]      rem_q, rem_d;
  logic [NumW-1:0]      quo_q, quo_d;
  logic                 bneg_q;
  logic signed [AW-1:0] a_q;
  logic                 refine_q;
  logic [DivCntW-1:0]   cnt_q;
  logic [DenW+1:0]      trial;

  // restoring divider, one quotient bit per step
  always_comb begin
    trial = {1'b0, rem_q, quo_q[NumW-1]} - {2'b00, den_q};
    if (!trial[DenW+1]) begin
      rem_d = trial[DenW-1:0];
      quo_d = {quo_q[NumW-2:0], 1'b1};
    end else begin
      rem_d = {rem_q[DenW-2:0], quo_q[NumW-1]};
      quo_d = {quo_q[NumW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      den_q  <= {dsum[CostW:0], 1'b0};
      rem_q  <= '0;
      quo_q  <= {absdiff, 4'b0000};
      bneg_q <= diff[CostW];
      a_q    <= {base, 4'b0000};
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refine_q <= 1'b0;
      cnt_q    <= '0;
    end else if (cmd_i.prep) begin
      refine_q <= s_int_q && (dsum != '0);
      cnt_q    <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + DivCntW'(1);
    end
  end

  // truncating correction and saturation
  logic signed [SumW-1:0] a_ext, q_ext, t, res;
  logic                   rnz;
  logic signed [DispW-1:0] sat;
  logic [BestExtW-1:0]     best_ext;

  always_comb begin
    a_ext = SumW'(a_q);
    q_ext = $signed(SumW'(quo_q));
    rnz   = (rem_q != '0);
    t     = bneg_q ? (a_ext - q_ext) : (a_ext + q_ext);
    if (!refine_q) begin
      res = a_ext;
    end else if (!bneg_q) begin
      res = (t < 0 && rnz) ? t + SumW'(1) : t;
    end else begin
      res = (t > 0 && rnz) ? t - SumW'(1) : t;
    end
    if (res > QMax) begin
      sat = DispW'(QMax);
    end else if (res < QMin) begin
      sat = DispW'(QMin);
    end else begin
      sat = res[DispW-1:0];
    end
    best_ext = BestExtW'(s_best_q);
  end

  logic signed [DispW-1:0] res_q, out_disp_q;
  logic [BestW-1:0]        res_best_q, out_best_q;
  logic                    res_ref_q, out_ref_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fix) begin
      res_q      <= sat;
      res_best_q <= best_ext[BestW-1:0];
      res_ref_q  <= refine_q;
    end
    if (cmd_i.emit) begin
      out_disp_q <= res_q;
      out_best_q <= res_best_q;
      out_ref_q  <= res_ref_q;
    end
  end

  assign st_o.last     = last;
  assign st_o.refine   = refine_q;
  assign st_o.div_done = (cnt_q == DivCntW'(DivSteps - 1));

  assign disparity_q4_o = out_disp_q;
  assign best_index_o   = out_best_q;
  assign refined_o      = out_ref_q;

endmodule

// ===== hw/rtl/disparity_wta_subpixel_core.sv =====
// channel   dir  handshake      payload
// cost_i    in   valid/ready    cost (32b unsigned, 24.8)
// disp_o    out  valid/ready    disparity_q4 (16b signed), best_index (8b), refined (1b)
// cfg       in   cfg_we_i       cfg_index_i, cfg_wdata_i (9b)
//
// one cost item is taken per cycle while cost_i is not stalled; a refined result passes
// prep, 36 steps of the radix-2 divider, fix and emit after its pixel's last cost, an
// unrefined one skips the divider steps; finishing overlaps the next pixel's costs; only
// the next pixel's last cost waits for the finisher
// async active-low reset, no clearing pass; a held result stalls the finisher in emit,
// and with it the next pixel's last cost
module disparity_wta_subpixel_core import dwta_pkg::*; #(
  parameter int MAX_DISPARITIES = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  dwta_cost_if.sink       cost_i,
  dwta_disp_if.source     disp_o,
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic [CfgW-1:0] cfg_wdata_i
);

  cmd_t    cmd;
  status_t st;
  logic    busy;

  dwta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cost_i.valid),
    .in_ready_o  (cost_i.ready),
    .out_ready_i (disp_o.ready),
    .out_valid_o (disp_o.valid),
    .busy_o      (busy),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  dwta_dp #(
    .MAX_DISPARITIES (MAX_DISPARITIES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cost_i         (cost_i.cost),
    .cmd_i          (cmd),
    .st_o           (st),
    .disparity_q4_o (disp_o.disparity_q4),
    .best_index_o   (disp_o.best_index),
    .refined_o      (disp_o.refined)
  );

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |-> !busy)
    else $error("pixel finished while finisher busy");

  a_start_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |=> cmd.prep)
    else $error("finished pixel not prepared");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (disp_o.valid && !disp_o.ready) |-> !cmd.emit)
    else $error("result overwritten while waiting");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> disp_o.valid)
    else $error("emitted item not shown");

endmodule

// ===== test/disparity_checker.sv =====
module disparity_checker import dwta_pkg::*; #(
  parameter int MaxDisparities = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  dwta_cost_if            cost_ch,
  dwta_disp_if            disp_ch,
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              results_o,
  output int              refined_o
);

  typedef struct packed {
    logic signed [DispW-1:0] q4;
    logic [BestW-1:0]        best;
    logic                    refined;
  } disp_t;

  logic [CfgW-1:0]        count_cfg;
  logic signed [CfgW-1:0] offset_cfg;

  int unsigned      cost_pos;
  int unsigned      low_idx;
  logic [CostW-1:0] prev_cost;
  logic [CostW-1:0] low_cost;
  logic [CostW-1:0] left_cost;
  logic [CostW-1:0] right_cost;
  logic             want_right;

  disp_t expected_disp[$];

  function automatic void clear_pixel();
    cost_pos   = 0;
    low_idx    = 0;
    prev_cost  = '0;
    low_cost   = '0;
    left_cost  = '0;
    right_cost = '0;
    want_right = 1'b0;
  endfunction

  // track the running minimum, queue a disparity when the pixel closes
  function automatic void absorb_cost(input logic [CostW-1:0] c);
    int unsigned span;
    longint      base;
    longint      q4;
    longint      c0;
    longint      c1;
    longint      c2;
    longint      den;
    disp_t       r;
    span = (count_cfg == 0) ? 1 : ((count_cfg > MaxDisparities) ? MaxDisparities : count_cfg);
    if (cost_pos == 0 || c < low_cost) begin
      low_cost   = c;
      low_idx    = cost_pos;
      left_cost  = prev_cost;
      want_right = 1'b1;
    end else if (want_right) begin
      right_cost = c;
      want_right = 1'b0;
    end
    prev_cost = c;
    if (cost_pos + 1 < span) begin
      cost_pos++;
      return;
    end
    base      = longint'(offset_cfg) + longint'(low_idx);
    q4        = base * 16;
    r.refined = 1'b0;
    if (low_idx > 0 && low_idx + 1 < span) begin
      c0  = {32'd0, left_cost};
      c1  = {32'd0, low_cost};
      c2  = {32'd0, right_cost};
      den = 2 * (c0 - 2 * c1 + c2);
      if (den != 0) begin
        q4        = (base * 16 * den + 16 * (c0 - c2)) / den;
        r.refined = 1'b1;
      end
    end
    if (q4 > QMax) q4 = QMax;
    if (q4 < QMin) q4 = QMin;
    r.q4   = q4[DispW-1:0];
    r.best = low_idx[BestW-1:0];
    expected_disp.push_back(r);
    clear_pixel();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    disp_t want;
    if (!rst_ni) begin
      count_cfg  = CountReset;
      offset_cfg = OffsetReset;
      clear_pixel();
      expected_disp.delete();
      fail_count_o = 0;
      results_o    = 0;
      refined_o    = 0;
    end else begin
      // a register written at this edge only affects later items
      if (cost_ch.valid && cost_ch.ready) begin
        absorb_cost(cost_ch.cost);
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CfgDispCount) begin
          count_cfg = cfg_wdata_i;
        end else begin
          offset_cfg = cfg_wdata_i;
        end
      end
      if (disp_ch.valid && disp_ch.ready) begin
        results_o++;
        if (disp_ch.refined === 1'b1) refined_o++;
        if (expected_disp.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with nothing expected, actual q4 %0d best %0d refined %0b",
                   $time, disp_ch.disparity_q4, disp_ch.best_index, disp_ch.refined);
        end else begin
          want = expected_disp.pop_front();
          if (disp_ch.disparity_q4 !== want.q4) begin
            fail_count_o++;
            $display("%0t: disparity_q4 expected %0d actual %0d",
                     $time, want.q4, disp_ch.disparity_q4);
          end
          if (disp_ch.best_index !== want.best) begin
            fail_count_o++;
            $display("%0t: best_index expected %0d actual %0d",
                     $time, want.best, disp_ch.best_index);
          end
          if (disp_ch.refined !== want.refined) begin
            fail_count_o++;
            $display("%0t: refined expected %0b actual %0b",
                     $time, want.refined, disp_ch.refined);
          end
        end
      end
    end
    pending_o = expected_disp.size();
  end

endmodule

// ===== test/tb_disparity_wta_subpixel_core.sv =====
module tb_disparity_wta_subpixel_core;
  import dwta_pkg::*;

  localparam int MaxDisparities = 256;
  localparam int ItemTarget     = 1925;
  localparam int SettleCycles   = 60;
  localparam int HoldCycles     = 400;
  localparam int QuietLimit     = 4000;

  localparam logic [CostW-1:0] CostTop    = '1;
  localparam logic [CfgW-1:0]  OffsetLow  = 9'h100;
  localparam logic [CfgW-1:0]  OffsetHigh = 9'h0FF;

  typedef enum logic [2:0] {
    ShapeValley,
    ShapeNoise,
    ShapeTies,
    ShapeFlat,
    ShapeRamp
  } shape_e;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic            cfg_index_i;
  logic [CfgW-1:0] cfg_wdata_i;

  dwta_cost_if cost_ch ();
  dwta_disp_if disp_ch ();

  int fail_count;
  int pending;
  int results;
  int refined_count;

  logic        calm;
  int          hold_asked = 0;
  int          hold_served;
  int unsigned items_sent;
  int unsigned reg_writes;
  logic        moved;

  disparity_wta_subpixel_core #(
    .MAX_DISPARITIES(MaxDisparities)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .cost_i(cost_ch),
    .disp_o(disp_ch),
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i
  );

  disparity_checker #(
    .MaxDisparities(MaxDisparities)
  ) u_checker (
    .clk_i,
    .rst_ni,
    .cost_ch(cost_ch),
    .disp_ch(disp_ch),
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .fail_count_o(fail_count),
    .pending_o(pending),
    .results_o(results),
    .refined_o(refined_count)
  );

  assign moved = (cost_ch.valid && cost_ch.ready) || (disp_ch.valid && disp_ch.ready);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int span_of(input logic [CfgW-1:0] c);
    if (c == 0) return 1;
    if (c > MaxDisparities) return MaxDisparities;
    return int'(c);
  endfunction

  task automatic send_cost(input logic [CostW-1:0] c);
    while (!calm && $urandom_range(99) < 12) begin
      cost_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cost_ch.valid <= 1'b1;
    cost_ch.cost  <= c;
    @(posedge clk_i);
    while (!cost_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_seq(input logic [CostW-1:0] seq[$]);
    foreach (seq[k]) send_cost(seq[k]);
  endtask

  task automatic write_reg(input logic idx, input logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
  endtask

  task automatic flush_results();
    cost_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // one cost profile per pixel, cut off after upto items
  task automatic send_pixel(input int span, input int upto);
    shape_e           shape;
    int               center;
    int               d;
    longint           slope;
    longint           level;
    longint           v;
    logic [CostW-1:0] c;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: shape = ShapeValley;
      5, 6:          shape = ShapeNoise;
      7:             shape = ShapeTies;
      8:             shape = ShapeFlat;
      default:       shape = ShapeRamp;
    endcase
    center = $urandom_range(span - 1);
    slope  = $urandom_range(16384);
    level  = $urandom >> $urandom_range(31);
    for (int i = 0; i < upto; i++) begin
      d = i - center;
      case (shape)
        ShapeValley: v = level + slope * d * d + $urandom_range(255);
        ShapeNoise:  v = $urandom;
        ShapeTies:   v = level + $urandom_range(2);
        ShapeFlat:   v = level;
        default:     v = center[0] ? level + slope * i : level + slope * (span - 1 - i);
      endcase
      c = (v > longint'(CostTop)) ? CostTop : v[CostW-1:0];
      send_cost(c);
    end
  endtask

  initial begin : result_sink
    disp_ch.ready = 1'b0;
    hold_served   = 0;
    forever begin
      @(posedge clk_i);
      if (hold_served < hold_asked) begin
        disp_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_served++;
      end else begin
        disp_ch.ready <= calm || ($urandom_range(99) >= 12);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      quiet = moved ? 0 : quiet + 1;
    end
    $display("%0t: no item moved for %0d cycles", $time, QuietLimit);
    $display("disparity_wta_subpixel_core verification failed");
    $finish;
  end

  initial begin : stimulus
    int              phase;
    int              span;
    int              pixels;
    logic            big;
    logic [CfgW-1:0] next_count;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CfgDispCount;
    cfg_wdata_i   = '0;
    cost_ch.valid = 1'b0;
    cost_ch.cost  = '0;
    calm          = 1'b0;
    items_sent    = 0;
    reg_writes    = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // edge minimum, interior minimum, ties, minimum at the end
    write_reg(CfgDispCount, 9'd3);
    write_reg(CfgDispOffset, 9'd0);
    send_seq('{32'd0, CostTop, CostTop});
    send_seq('{CostTop, 32'd0, CostTop});
    send_seq('{32'd5, 32'd5, 32'd5});
    send_seq('{32'd9, 32'd4, 32'd4});
    send_seq('{32'd9, 32'd8, 32'd1});
    flush_results();
    write_reg(CfgDispOffset, OffsetLow);
    send_seq('{32'd10, 32'd3, 32'd7});
    flush_results();
    write_reg(CfgDispOffset, OffsetHigh);
    send_seq('{32'd7, 32'd3, 32'd10});
    flush_results();
    // zero count behaves as one
    write_reg(CfgDispCount, 9'd0);
    send_seq('{32'd0, CostTop});
    flush_results();
    // shrink the count while a pixel is open
    write_reg(CfgDispCount, 9'd4);
    send_seq('{32'd6, 32'd2, 32'd8});
    flush_results();
    write_reg(CfgDispCount, 9'd3);
    send_seq('{32'd1});
    flush_results();

    phase = 0;
    while (items_sent < ItemTarget) begin
      big = (phase == 3) || (phase == 9);
      if (phase == 3) begin
        next_count = 9'd256;
      end else if (phase == 9) begin
        next_count = 9'd511;
      end else if (phase == 1) begin
        next_count = 9'd2;
      end else begin
        case ($urandom_range(7))
          0:       next_count = 9'd0;
          1:       next_count = 9'd1;
          2:       next_count = 9'd2;
          3:       next_count = 9'd3;
          4, 5:    next_count = CfgW'($urandom_range(12, 4));
          default: next_count = CfgW'($urandom_range(48, 13));
        endcase
      end
      write_reg(CfgDispCount, next_count);
      case ($urandom_range(3))
        0:       write_reg(CfgDispOffset, OffsetLow);
        1:       write_reg(CfgDispOffset, OffsetHigh);
        default: write_reg(CfgDispOffset, CfgW'($urandom_range(511)));
      endcase
      calm = (phase >= 5 && phase < 8);
      // long output stall so the input backs up
      if (phase == 1) hold_asked++;
      span   = span_of(next_count);
      pixels = big ? 1 : $urandom_range(2, 1) + 72 / span;
      repeat (pixels) send_pixel(span, span);
      if (!big && span > 1 && $urandom_range(2) == 0) begin
        send_pixel(span, $urandom_range(span - 1, 1));
      end
      flush_results();
      phase++;
    end
    calm = 1'b0;

    $display("covered %0d cost items over %0d register writes in %0d phases", items_sent,
             reg_writes, phase);
    $display("checked %0d disparities, %0d of them sub-pixel refined", results, refined_count);
    if (fail_count == 0) begin
      $display("disparity_wta_subpixel_core verification clean");
    end else begin
      $display("disparity_wta_subpixel_core verification failed");
    end
    $finish;
  end

endmodule

// ===== disparity_wta_subpixel_core.f =====
hw/rtl/dwta_pkg.sv
hw/rtl/dwta_cost_if.sv
hw/rtl/dwta_disp_if.sv
hw/rtl/dwta_ctrl.sv
hw/rtl/dwta_dp.sv
hw/rtl/disparity_wta_subpixel_core.sv
test/disparity_checker.sv
test/tb_disparity_wta_subpixel_core.sv
